// ===== rtl/msrch_pkg.sv =====
// ----------------------------------------------------------------------------
// msrch_pkg
// Shared widths, codes and controller/datapath interface types for the
// multi-way sorted search block.
// ----------------------------------------------------------------------------
`default_nettype none

package msrch_pkg;

    localparam int ADDR_W      = 10;
    localparam int VALUE_W     = 32;
    localparam int LEN_W       = 11;
    localparam int POS_W       = 10;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 16;

    localparam int DEPTH_DEF = 1024;
    localparam int LANES_DEF = 4;

    localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    typedef struct packed {
        logic mem_we;
        logic search_init;
        logic div_start;
        logic lane_init;
        logic lane_adv;
        logic rd_first;
        logic rd_last;
        logic chk_first;
        logic chk_last;
        logic round_commit;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic win_empty;
        logic div_done;
        logic seg_empty;
        logic last_lane;
        logic key_eq;
        logic narrowed;
        logic out_busy;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== rtl/multiway_sorted_search.sv =====
// ----------------------------------------------------------------------------
// multiway_sorted_search
// Sorted word store with a multi-lane parallel binary search.
//
// Input stream: tuser selects load (store tdata value at tdata address) or
// search (tdata value is the key). Output stream: one beat per search, tuser
// is the found flag and tdata the matching position (zero when not found).
// The length register sets how many leading entries take part in a search.
//
// A load leaves ready high. A search runs for R rounds, where R is roughly
// log base LANES of the length (five at the defaults). Each round passes
// through the window check, the lane count divider, the lanes and the
// narrowing decision. Each lane steps its boundaries and, unless its segment
// is empty, fetches the segment's first and last entries one after the other
// through the single store read port.
// Ready is low while a search runs. A finished result waits in the output
// register; loads and a new search are still taken while it waits, and a
// search that finishes before the receiver takes it holds until it does.
// Reset empties the output register, returns the sequencer to idle and sets
// the length to 1024; store contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module multiway_sorted_search #(
    parameter int DEPTH = msrch_pkg::DEPTH_DEF,
    parameter int LANES = msrch_pkg::LANES_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_s_axis_tvalid,
    output logic                                      o_s_axis_tready,
    // [9:0] address, [41:10] value, [47:42] zero
    input  wire logic [msrch_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // [0] action
    input  wire logic                                 i_s_axis_tuser,
    output logic                                      o_m_axis_tvalid,
    input  wire logic                                 i_m_axis_tready,
    // [9:0] position, [15:10] zero
    output logic      [msrch_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // [0] found
    output logic                                      o_m_axis_tuser,
    input  wire logic                                 i_cfg_we,
    input  wire logic [msrch_pkg::LEN_W-1:0]          i_cfg_data
);

    localparam int AD_W = msrch_pkg::ADDR_W;
    localparam int VL_W = msrch_pkg::VALUE_W;

    msrch_pkg::t_dp_cmd  dp_cmd;
    msrch_pkg::t_dp_stat dp_stat;
    logic [msrch_pkg::POS_W-1:0] out_pos;

    msrch_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_action (i_s_axis_tuser),
        .o_in_ready  (o_s_axis_tready),
        .o_cmd       (dp_cmd),
        .i_stat      (dp_stat)
    );

    msrch_dp #(
        .DEPTH (DEPTH),
        .LANES (LANES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_address      (i_s_axis_tdata[AD_W-1:0]),
        .i_value        ($signed(i_s_axis_tdata[AD_W+VL_W-1:AD_W])),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (i_m_axis_tready),
        .o_out_valid    (o_m_axis_tvalid),
        .o_out_found    (o_m_axis_tuser),
        .o_out_position (out_pos)
    );

    assign o_m_axis_tdata = {(msrch_pkg::OUT_TDATA_W - msrch_pkg::POS_W)'(0), out_pos};

    // A not-found result always carries position zero.
    a_notfound_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("not-found result with nonzero position");

    // A search beat makes the block busy in the next cycle.
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser == msrch_pkg::ACT_SEARCH)
        |=> !o_s_axis_tready)
        else $error("ready stayed high after a search beat");

    // A load beat never stalls the input.
    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser == msrch_pkg::ACT_LOAD)
        |=> o_s_axis_tready)
        else $error("ready dropped after a load beat");

    // A new result only appears at the end of a running search.
    a_result_from_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> !$past(o_s_axis_tready))
        else $error("result appeared without a search in progress");

endmodule

`default_nettype wire

// ===== rtl/msrch_div.sv =====
// ----------------------------------------------------------------------------
// msrch_div
// Divides the window size by the lane count by multiplying with the rounded-up
// reciprocal; quotient and remainder are registered, ready in the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module msrch_div #(
    parameter int WW    = 11,
    parameter int LANES = msrch_pkg::LANES_DEF,
    parameter int RW    = 3
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [WW-1:0] i_dividend,
    output logic      [WW-1:0] o_quot,
    output logic      [RW-1:0] o_rem,
    output logic               o_done
);

    localparam int LG = $clog2(LANES);
    localparam int K  = WW + LG;
    localparam int MW = WW + 1;
    localparam int PW = WW + MW;

    // The reciprocal overshoots 2^K by less than LANES, which keeps the
    // quotient exact for every dividend below 2^WW.
    localparam logic [MW-1:0] RECIP = MW'(((1 << K) + LANES - 1) / LANES);

    logic [PW-1:0] prod;
    logic [WW-1:0] quot;
    logic [RW-1:0] rem;
    logic          r_done;
    logic [WW-1:0] r_quot;
    logic [RW-1:0] r_rem;

    assign prod = PW'(i_dividend) * PW'(RECIP);
    assign quot = WW'(prod >> K);
    assign rem  = RW'(i_dividend - WW'(quot * WW'(LANES)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
        if (i_start) begin
            r_quot <= quot;
            r_rem  <= rem;
        end
    end

    assign o_quot = r_quot;
    assign o_rem  = r_rem;
    assign o_done = r_done;

endmodule

`default_nettype wire

// ===== rtl/msrch_dp.sv =====
// ----------------------------------------------------------------------------
// msrch_dp
// Search datapath: sorted store, search window, lane boundary stepping,
// key comparison and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module msrch_dp #(
    parameter int DEPTH = msrch_pkg::DEPTH_DEF,
    parameter int LANES = msrch_pkg::LANES_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire msrch_pkg::t_dp_cmd                    i_cmd,
    output msrch_pkg::t_dp_stat                        o_stat,
    input  wire logic        [msrch_pkg::ADDR_W-1:0]   i_address,
    input  wire logic signed [msrch_pkg::VALUE_W-1:0]  i_value,
    input  wire logic                                  i_cfg_we,
    input  wire logic        [msrch_pkg::LEN_W-1:0]    i_cfg_data,
    input  wire logic                                  i_out_ready,
    output logic                                       o_out_valid,
    output logic                                       o_out_found,
    output logic             [msrch_pkg::POS_W-1:0]    o_out_position
);

    localparam int AW = $clog2(DEPTH);
    localparam int WW = $clog2(DEPTH + 1);
    localparam int RW = $clog2(LANES) + 1;
    localparam int NW = $clog2(LANES + 1);

    logic signed [msrch_pkg::VALUE_W-1:0] r_mem [DEPTH];
    logic signed [msrch_pkg::VALUE_W-1:0] r_rdata;
    logic signed [msrch_pkg::VALUE_W-1:0] r_key;
    logic signed [msrch_pkg::VALUE_W-1:0] r_first;
    logic [msrch_pkg::LEN_W-1:0]          r_len;
    logic [WW-1:0]                        r_low, r_high;
    logic [WW-1:0]                        r_a, r_b, r_q;
    logic [RW-1:0]                        r_r;
    logic [NW-1:0]                        r_lane;
    logic                                 r_narrowed;
    logic [WW-1:0]                        r_new_low, r_new_high;
    logic                                 r_hit;
    logic [AW-1:0]                        r_where;
    logic                                 r_out_valid;
    logic                                 r_out_found;
    logic [msrch_pkg::POS_W-1:0]          r_out_pos;

    logic [WW-1:0] len_clamped;
    logic [WW-1:0] size;
    logic [WW-1:0] div_quot;
    logic [RW-1:0] div_rem;
    logic          div_done;
    logic [RW-1:0] sum_r;
    logic          carry;
    logic [RW-1:0] n_r;
    logic [WW-1:0] n_q;
    logic [WW-1:0] seg_start, seg_endm1;
    logic [AW-1:0] rd_addr;
    logic          key_eq;
    logic          addr_ok;

    assign len_clamped = (32'(r_len) > 32'(DEPTH)) ? WW'(DEPTH) : WW'(r_len);
    assign size        = r_high - r_low;

    msrch_div #(
        .WW    (WW),
        .LANES (LANES),
        .RW    (RW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (size),
        .o_quot     (div_quot),
        .o_rem      (div_rem),
        .o_done     (div_done)
    );

    // Next boundary floor((i+1)*size/LANES) from the running quotient and
    // remainder; both remainders are below LANES, so one correction suffices.
    assign sum_r = r_r + div_rem;
    assign carry = sum_r >= RW'(LANES);
    assign n_r   = carry ? sum_r - RW'(LANES) : sum_r;
    assign n_q   = r_q + div_quot + WW'(carry);

    assign seg_start = r_low + r_a;
    assign seg_endm1 = r_low + r_b - 1'b1;
    assign rd_addr   = i_cmd.rd_first ? AW'(seg_start) : AW'(seg_endm1);
    assign key_eq    = r_rdata == r_key;
    assign addr_ok   = 32'(i_address) < 32'(DEPTH);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we && addr_ok) begin
            r_mem[AW'(i_address)] <= i_value;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= msrch_pkg::LEN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_len <= i_cfg_data;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end
        end

        if (i_cmd.search_init) begin
            r_key  <= i_value;
            r_low  <= '0;
            r_high <= len_clamped;
            r_hit  <= 1'b0;
        end
        if (i_cmd.lane_init) begin
            r_a        <= '0;
            r_b        <= '0;
            r_q        <= '0;
            r_r        <= '0;
            r_lane     <= '0;
            r_narrowed <= 1'b0;
        end
        if (i_cmd.lane_adv) begin
            r_a    <= r_b;
            r_b    <= n_q;
            r_q    <= n_q;
            r_r    <= n_r;
            r_lane <= r_lane + 1'b1;
        end
        if (i_cmd.chk_first) begin
            r_first <= r_rdata;
            if (key_eq) begin
                r_hit   <= 1'b1;
                r_where <= AW'(seg_start);
            end
        end
        if (i_cmd.chk_last) begin
            if (key_eq) begin
                r_hit   <= 1'b1;
                r_where <= AW'(seg_endm1);
            end else if (!r_narrowed && (r_first < r_key) && (r_key < r_rdata)) begin
                r_narrowed <= 1'b1;
                r_new_low  <= seg_start + 1'b1;
                r_new_high <= seg_endm1;
            end
        end
        if (i_cmd.round_commit) begin
            r_low  <= r_new_low;
            r_high <= r_new_high;
        end
        if (i_cmd.out_load) begin
            r_out_found <= r_hit;
            r_out_pos   <= r_hit ? msrch_pkg::POS_W'(r_where) : '0;
        end
    end

    always_comb begin
        o_stat           = '0;
        o_stat.win_empty = r_high <= r_low;
        o_stat.div_done  = div_done;
        o_stat.seg_empty = r_a >= r_b;
        o_stat.last_lane = r_lane == NW'(LANES);
        o_stat.key_eq    = key_eq;
        o_stat.narrowed  = r_narrowed;
        o_stat.out_busy  = r_out_valid && !i_out_ready;
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_found    = r_out_found;
    assign o_out_position = r_out_pos;

endmodule

`default_nettype wire

// ===== rtl/msrch_ctrl.sv =====
// ----------------------------------------------------------------------------
// msrch_ctrl
// Sequencer for loads and searches: steps rounds and lanes, issues store
// reads and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module msrch_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_action,
    output logic                     o_in_ready,
    output msrch_pkg::t_dp_cmd       o_cmd,
    input  wire msrch_pkg::t_dp_stat i_stat
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_WIN,
        S_DIV,
        S_ADV,
        S_SEG,
        S_FIRST,
        S_LAST,
        S_ROUND,
        S_DONE
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = r_state == S_IDLE;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_action == msrch_pkg::ACT_SEARCH) begin
                        o_cmd.search_init = 1'b1;
                        n_state           = S_WIN;
                    end else begin
                        o_cmd.mem_we = 1'b1;
                    end
                end
            end
            S_WIN: begin
                if (i_stat.win_empty) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.lane_init = 1'b1;
                    n_state         = S_ADV;
                end
            end
            S_ADV: begin
                o_cmd.lane_adv = 1'b1;
                n_state        = S_SEG;
            end
            S_SEG: begin
                if (i_stat.seg_empty) begin
                    n_state = i_stat.last_lane ? S_ROUND : S_ADV;
                end else begin
                    o_cmd.rd_first = 1'b1;
                    n_state        = S_FIRST;
                end
            end
            S_FIRST: begin
                // The first entry arrives while the last one is being read.
                o_cmd.rd_last   = 1'b1;
                o_cmd.chk_first = 1'b1;
                n_state         = i_stat.key_eq ? S_DONE : S_LAST;
            end
            S_LAST: begin
                o_cmd.chk_last = 1'b1;
                if (i_stat.key_eq) begin
                    n_state = S_DONE;
                end else begin
                    n_state = i_stat.last_lane ? S_ROUND : S_ADV;
                end
            end
            S_ROUND: begin
                if (i_stat.narrowed) begin
                    o_cmd.round_commit = 1'b1;
                    n_state            = S_WIN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire
